// ===== design/tce_pkg.sv =====
// ----------------------------------------------------------------------------
// tce_pkg
// Shared constants and types of the text console engine: control character
// codes, default screen geometry, sequencer states and the result record.
// ----------------------------------------------------------------------------
package tce_pkg;

	// default screen geometry
	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;

	// control characters
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// tab stops and the bound on spaces emitted by one tab
	localparam int TAB_STOP  = 8;
	localparam int TAB_GUARD = 2 * TAB_STOP;

	// attribute reset value
	localparam logic [7:0] ATTR_RESET = 8'h01;

	// request opcodes
	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	// sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_PRINT,
		ST_SCROLL_COPY,
		ST_SCROLL_MASK,
		ST_SCROLL_DRAIN,
		ST_DONE
	} tce_state_t;

	// finished result handed from the sequencer to the output stage
	typedef struct packed {
		logic       valid;
		logic [4:0] caret_row;
		logic [6:0] caret_col;
		logic [7:0] cell_char;
		logic [7:0] cell_attr;
	} tce_res_t;

endpackage

// ===== design/tce_screen_ram.sv =====
// ----------------------------------------------------------------------------
// tce_screen_ram
// Screen cell store: one write port and one read port, read data
// registered (old data on a same-address collision).
// ----------------------------------------------------------------------------
module tce_screen_ram
	import tce_pkg::*;
#(
	parameter int DEPTH = DEF_ROWS * DEF_COLUMNS,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [15:0]   wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [15:0]   rd_data
);

	logic [15:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== design/tce_sequencer.sv =====
// ----------------------------------------------------------------------------
// tce_sequencer
// Console control: cursor registers, character decode, tab expansion,
// wrap, backspace, cell reads, the screen scroll sweep and the clearing
// pass after reset. Drives the screen store ports.
// ----------------------------------------------------------------------------
module tce_sequencer
	import tce_pkg::*;
#(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS,
	localparam int DEPTH  = ROWS * COLUMNS,
	localparam int AW     = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	// request side
	input  logic          req_valid,
	output logic          idle,
	input  logic          op,
	input  logic [7:0]    char_code,
	input  logic [4:0]    read_row,
	input  logic [6:0]    read_col,
	input  logic [7:0]    attr,
	// result side
	output tce_res_t      res,
	input  logic          out_free,
	// screen store
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output logic [15:0]   wr_data,
	output logic          rd_en,
	output logic [AW-1:0] rd_addr,
	input  logic [15:0]   rd_data
);

	localparam int RW = $clog2(ROWS);
	localparam int CW = $clog2(COLUMNS + 1);
	localparam int GW = $clog2(TAB_GUARD + 1);

	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
	localparam logic [AW-1:0] BOT_BASE  = AW'((ROWS - 1) * COLUMNS);
	localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
	localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
	localparam logic [CW-1:0] COL_END   = CW'(COLUMNS);
	localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
	localparam logic [GW-1:0] GUARD_MAX = GW'(TAB_GUARD);

	tce_state_t state_q, state_d;

	logic [RW-1:0] row_q, row_d;
	logic [CW-1:0] col_q, col_d;
	logic [7:0]    ch_q, ch_d;
	logic          tab_q, tab_d;
	logic [GW-1:0] guard_q, guard_d;
	logic          ret_print_q, ret_print_d;
	logic [AW-1:0] sweep_q, sweep_d;
	logic          hit_q, hit_d;
	logic [7:0]    res_char_q, res_char_d;
	logic [7:0]    res_attr_q, res_attr_d;

	// scroll write, issued in the cycle after its read
	logic          cp_wr_s1, cp_wr_d;
	logic [AW-1:0] cp_addr_s1, cp_addr_d;
	logic          cp_mask_s1, cp_mask_d;

	logic [CW-1:0] col_inc;
	logic [CW-1:0] col_dec;
	logic [GW-1:0] guard_inc;
	logic          rd_in_range;

	function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
	                                            input logic [CW-1:0] c);
		return AW'(32'(r) * COLUMNS + 32'(c));
	endfunction

	assign col_inc     = col_q + 1'b1;
	assign col_dec     = (col_q - 1'b1 >= COL_END) ? LAST_COL : col_q - 1'b1;
	assign guard_inc   = guard_q + 1'b1;
	assign rd_in_range = (32'(read_row) < ROWS) && (32'(read_col) < COLUMNS);

	// state and payload registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			row_q    <= '0;
			col_q    <= '0;
			sweep_q  <= '0;
			cp_wr_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			row_q    <= row_d;
			col_q    <= col_d;
			sweep_q  <= sweep_d;
			cp_wr_s1 <= cp_wr_d;
		end
	end

	always_ff @(posedge clk) begin
		ch_q        <= ch_d;
		tab_q       <= tab_d;
		guard_q     <= guard_d;
		ret_print_q <= ret_print_d;
		hit_q       <= hit_d;
		res_char_q  <= res_char_d;
		res_attr_q  <= res_attr_d;
		cp_addr_s1  <= cp_addr_d;
		cp_mask_s1  <= cp_mask_d;
	end

	// next state and store control
	always_comb begin
		state_d     = state_q;
		row_d       = row_q;
		col_d       = col_q;
		ch_d        = ch_q;
		tab_d       = tab_q;
		guard_d     = guard_q;
		ret_print_d = ret_print_q;
		sweep_d     = sweep_q;
		hit_d       = hit_q;
		res_char_d  = res_char_q;
		res_attr_d  = res_attr_q;
		cp_wr_d     = 1'b0;
		cp_addr_d   = cp_addr_s1;
		cp_mask_d   = 1'b0;

		rd_en   = 1'b0;
		rd_addr = sweep_q;
		// pending scroll write by default
		wr_en   = cp_wr_s1;
		wr_addr = cp_addr_s1;
		wr_data = cp_mask_s1 ? {rd_data[15:8], 8'h00} : rd_data;

		idle = (state_q == ST_IDLE);
		res  = '{valid:     (state_q == ST_DONE),
		         caret_row: 5'(row_q),
		         caret_col: 7'(col_q),
		         cell_char: res_char_q,
		         cell_attr: res_attr_q};

		case (state_q)
			// zero the whole store after reset
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = sweep_q;
				wr_data = '0;
				if (sweep_q == LAST_ADDR) begin
					sweep_d = '0;
					state_d = ST_IDLE;
				end else begin
					sweep_d = sweep_q + 1'b1;
				end
			end

			// take a request and decode it
			ST_IDLE: begin
				if (req_valid) begin
					res_char_d = '0;
					res_attr_d = '0;
					hit_d      = 1'b0;
					if (op == OP_READ) begin
						hit_d   = rd_in_range;
						rd_en   = rd_in_range;
						rd_addr = AW'(32'(read_row) * COLUMNS + 32'(read_col));
						state_d = ST_READ;
					end else begin
						case (char_code)
							CH_TAB: begin
								ch_d    = CH_SPACE;
								tab_d   = 1'b1;
								guard_d = '0;
								state_d = ST_PRINT;
							end
							CH_CR: begin
								col_d   = '0;
								state_d = ST_DONE;
							end
							CH_LF: begin
								col_d = '0;
								if (row_q == LAST_ROW) begin
									ret_print_d = 1'b0;
									sweep_d     = ROW_STEP;
									state_d     = ST_SCROLL_COPY;
								end else begin
									row_d   = row_q + 1'b1;
									state_d = ST_DONE;
								end
							end
							CH_BS: begin
								state_d = ST_DONE;
								if (col_q != '0) begin
									col_d   = col_dec;
									wr_en   = 1'b1;
									wr_addr = cell_addr(row_q, col_dec);
									wr_data = {attr, CH_SPACE};
								end else if (row_q != '0) begin
									col_d   = LAST_COL;
									row_d   = row_q - 1'b1;
									wr_en   = 1'b1;
									wr_addr = cell_addr(row_q - 1'b1, LAST_COL);
									wr_data = {attr, CH_SPACE};
								end
							end
							default: begin
								ch_d    = char_code;
								tab_d   = 1'b0;
								state_d = ST_PRINT;
							end
						endcase
					end
				end
			end

			// cell read data is back
			ST_READ: begin
				if (hit_q) begin
					res_char_d = rd_data[7:0];
					res_attr_d = rd_data[15:8];
				end
				state_d = ST_DONE;
			end

			// one printable character, with lazy wrap first
			ST_PRINT: begin
				if (col_q >= COL_END) begin
					col_d = '0;
					if (row_q == LAST_ROW) begin
						ret_print_d = 1'b1;
						sweep_d     = ROW_STEP;
						state_d     = ST_SCROLL_COPY;
					end else begin
						row_d = row_q + 1'b1;
					end
				end else begin
					wr_en   = 1'b1;
					wr_addr = cell_addr(row_q, col_q);
					wr_data = {attr, ch_q};
					col_d   = col_inc;
					guard_d = guard_inc;
					if (!(tab_q && (col_inc % TAB_STOP != '0) && (guard_inc < GUARD_MAX))) begin
						state_d = ST_DONE;
					end
				end
			end

			// move every row up by one
			ST_SCROLL_COPY: begin
				rd_en     = 1'b1;
				rd_addr   = sweep_q;
				cp_wr_d   = 1'b1;
				cp_addr_d = sweep_q - ROW_STEP;
				if (sweep_q == LAST_ADDR) begin
					sweep_d = BOT_BASE;
					state_d = ST_SCROLL_MASK;
				end else begin
					sweep_d = sweep_q + 1'b1;
				end
			end

			// blank the bottom row's characters, keep its attributes
			ST_SCROLL_MASK: begin
				rd_en     = 1'b1;
				rd_addr   = sweep_q;
				cp_wr_d   = 1'b1;
				cp_addr_d = sweep_q;
				cp_mask_d = 1'b1;
				if (sweep_q == LAST_ADDR) begin
					state_d = ST_SCROLL_DRAIN;
				end else begin
					sweep_d = sweep_q + 1'b1;
				end
			end

			// last scroll write goes out here
			ST_SCROLL_DRAIN: begin
				state_d = ret_print_q ? ST_PRINT : ST_DONE;
			end

			// hold the result until the output stage takes it
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/text_console_engine.sv =====
// ----------------------------------------------------------------------------
// text_console_engine
// Character console writing attribute and character cells into an on-chip
// screen store, with tab, carriage return, line feed, backspace, wrap,
// scroll and cell read-back.
// ----------------------------------------------------------------------------
// After reset the block zeroes all ROWS*COLUMNS cells of the screen store
// (2000 at the default 80x25) and stalls requests meanwhile; the
// attribute register can be written during that time. A cell read passes
// through ST_READ and a printable character through ST_PRINT, and the
// result is then loaded from ST_DONE into the output register. Carriage
// return, backspace and a line feed that stays on screen go straight to
// ST_DONE. A tab writes one space per pass through ST_PRINT, and a wrap
// onto the next row takes an extra pass. Any step past the bottom row runs
// a scroll sweep through the single store port pair, one cell a cycle:
// copy every row up, blank the bottom row, drain the last write. Every
// request produces one result; the output register lets the next request
// be accepted while a result still waits.
module text_console_engine
	import tce_pkg::*;
#(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_write_en,
	input  logic [7:0] cfg_write_data,
	// request channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       op,
	input  logic [7:0] char_code,
	input  logic [4:0] read_row,
	input  logic [6:0] read_col,
	// result channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [4:0] caret_row,
	output logic [6:0] caret_col,
	output logic [7:0] cell_char,
	output logic [7:0] cell_attr
);

	localparam int DEPTH = ROWS * COLUMNS;
	localparam int AW    = $clog2(DEPTH);

	logic [7:0]    attr_q;
	logic          seq_idle;
	tce_res_t      seq_res;
	logic          out_free;
	logic          out_valid_q;
	logic [4:0]    caret_row_q;
	logic [6:0]    caret_col_q;
	logic [7:0]    cell_char_q;
	logic [7:0]    cell_attr_q;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [15:0]   wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [15:0]   rd_data;

	// attribute register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (cfg_write_en) begin
			attr_q <= cfg_write_data;
		end
	end

	assign in_stall = !seq_idle;
	assign out_free = !out_valid_q || !out_stall;

	tce_sequencer #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (in_valid),
		.idle      (seq_idle),
		.op        (op),
		.char_code (char_code),
		.read_row  (read_row),
		.read_col  (read_col),
		.attr      (attr_q),
		.res       (seq_res),
		.out_free  (out_free),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	tce_screen_ram #(
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq_res.valid && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (seq_res.valid && out_free) begin
			caret_row_q <= seq_res.caret_row;
			caret_col_q <= seq_res.caret_col;
			cell_char_q <= seq_res.cell_char;
			cell_attr_q <= seq_res.cell_attr;
		end
	end

	assign out_valid = out_valid_q;
	assign caret_row = caret_row_q;
	assign caret_col = caret_col_q;
	assign cell_char = cell_char_q;
	assign cell_attr = cell_attr_q;

endmodule

// ===== test/text_console_engine_test.sv =====
// ----------------------------------------------------------------------------
// text_console_engine_test
// Self-checking bench for the text console engine. A directed table covers
// reads at the screen extremes and out of range, backspace at the top-left
// and during a pending wrap, tab, carriage return and line feed. Random
// character traffic follows under several attribute settings and drives
// the cursor through wraps and scrolls. Each result is checked against the
// table's expected view where it gives one, else against a screen mirror
// kept in the bench, with random request gaps and result stalls.
// ----------------------------------------------------------------------------
module text_console_engine_test;
	import tce_pkg::*;

	localparam int COLUMNS        = DEF_COLUMNS;
	localparam int ROWS           = DEF_ROWS;
	localparam int PHASE_ITEMS    = 200;
	localparam int DRAIN_CYCLES   = 16;
	localparam int RUN_LIMIT      = 10000000;
	localparam int PRINT_LIMIT    = 40;

	// cursor and cell carried by one result
	typedef struct packed {
		logic [4:0] row;
		logic [6:0] col;
		logic [7:0] ch;
		logic [7:0] attr;
	} console_view_t;

	// one request of the directed table, with its result where it is obvious
	typedef struct packed {
		logic          op;
		logic [7:0]    ch;
		logic [4:0]    rr;
		logic [6:0]    rc;
		logic          typed;
		console_view_t want;
	} directed_row_t;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_RUNS
	} stall_mode_t;

	logic       clk            = 1'b0;
	logic       arst_n         = 1'b0;
	logic       cfg_write_en   = 1'b0;
	logic [7:0] cfg_write_data = 8'h00;
	logic       in_valid       = 1'b0;
	logic       in_stall;
	logic       op             = OP_PUT;
	logic [7:0] char_code      = 8'h00;
	logic [4:0] read_row       = 5'd0;
	logic [6:0] read_col       = 7'd0;
	logic       out_valid;
	logic       out_stall      = 1'b0;
	logic [4:0] caret_row;
	logic [6:0] caret_col;
	logic [7:0] cell_char;
	logic [7:0] cell_attr;

	text_console_engine #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.char_code(char_code),
		.read_row(read_row),
		.read_col(read_col),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.caret_row(caret_row),
		.caret_col(caret_col),
		.cell_char(cell_char),
		.cell_attr(cell_attr)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// screen mirror
	// ------------------------------------------------------------------
	logic [15:0]   screen_mirror [ROWS*COLUMNS];
	int            cur_row;
	int            cur_col;
	logic [7:0]    attr_shadow;
	console_view_t cursor_cell_q [$];
	int            mismatch_count;
	int            result_index;
	int            cycle_count;

	function automatic void mirror_put_cell(logic [7:0] ch);
		if (cur_row < ROWS && cur_col < COLUMNS)
			screen_mirror[cur_row*COLUMNS + cur_col] = {attr_shadow, ch};
	endfunction

	// rows move up by one, bottom row keeps attributes only
	function automatic void mirror_scroll();
		for (int r = 1; r < ROWS; r++)
			for (int c = 0; c < COLUMNS; c++)
				screen_mirror[(r-1)*COLUMNS + c] = screen_mirror[r*COLUMNS + c];
		for (int c = 0; c < COLUMNS; c++)
			screen_mirror[(ROWS-1)*COLUMNS + c] &= 16'hFF00;
	endfunction

	function automatic void mirror_next_row();
		cur_row++;
		if (cur_row >= ROWS) begin
			cur_row = ROWS - 1;
			mirror_scroll();
		end
	endfunction

	// lazy wrap, then write and step
	function automatic void mirror_printable(logic [7:0] ch);
		if (cur_col >= COLUMNS) begin
			mirror_next_row();
			cur_col = 0;
		end
		mirror_put_cell(ch);
		cur_col++;
	endfunction

	function automatic void mirror_emit(logic [7:0] ch);
		int guard;
		case (ch)
			CH_TAB: begin
				guard = 0;
				do begin
					mirror_printable(CH_SPACE);
					guard++;
				end while ((cur_col % TAB_STOP) != 0 && guard < TAB_GUARD);
			end
			CH_CR: begin
				cur_col = 0;
			end
			CH_LF: begin
				cur_col = 0;
				mirror_next_row();
			end
			CH_BS: begin
				// nothing happens at the top-left
				if (cur_col > 0) begin
					cur_col--;
					if (cur_col >= COLUMNS)
						cur_col = COLUMNS - 1;
					mirror_put_cell(CH_SPACE);
				end else if (cur_row > 0) begin
					cur_col = COLUMNS - 1;
					cur_row--;
					mirror_put_cell(CH_SPACE);
				end
			end
			default: begin
				mirror_printable(ch);
			end
		endcase
	endfunction

	function automatic console_view_t predict_request(logic o, logic [7:0] ch,
			logic [4:0] rr, logic [6:0] rc);
		console_view_t v;
		logic [15:0]   cell_word;
		cell_word = 16'h0000;
		if (o == OP_PUT)
			mirror_emit(ch);
		else if (int'(rr) < ROWS && int'(rc) < COLUMNS)
			cell_word = screen_mirror[int'(rr)*COLUMNS + int'(rc)];
		v.row  = cur_row[4:0];
		v.col  = cur_col[6:0];
		v.ch   = cell_word[7:0];
		v.attr = cell_word[15:8];
		return v;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_LIMIT)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	// ------------------------------------------------------------------
	// request side: bursts separated by random gaps
	// ------------------------------------------------------------------
	int burst_left;
	bit quiet_bursts;

	task automatic send_request(input logic o, input logic [7:0] ch, input logic [4:0] rr,
			input logic [6:0] rc, input logic typed, input console_view_t want);
		int            gap;
		console_view_t v;
		gap = 0;
		if (burst_left == 0) begin
			burst_left   = $urandom_range(1, 24);
			quiet_bursts = ($urandom_range(0, 3) == 0);
			gap          = quiet_bursts ? 0 : $urandom_range(1, 7);
		end
		burst_left--;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		op        <= o;
		char_code <= ch;
		read_row  <= rr;
		read_col  <= rc;
		do @(posedge clk); while (in_stall);
		v = predict_request(o, ch, rr, rc);
		cursor_cell_q.push_back(typed ? want : v);
	endtask

	// stop sending and wait for every result
	task automatic drain_results();
		in_valid <= 1'b0;
		while (cursor_cell_q.size() != 0) @(posedge clk);
	endtask

	task automatic set_attribute(input logic [7:0] value);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= value;
		@(posedge clk);
		cfg_write_en   <= 1'b0;
		attr_shadow     = value;
	endtask

	// ------------------------------------------------------------------
	// directed table
	// ------------------------------------------------------------------
	localparam console_view_t NO_VIEW = '0;

	directed_row_t directed_table [25] = '{
		'{OP_READ, 8'h00, 5'd0,  7'd0,   1'b1, '{5'd0, 7'd0,  8'h00, 8'h00}},
		'{OP_READ, 8'h00, 5'd24, 7'd79,  1'b1, '{5'd0, 7'd0,  8'h00, 8'h00}},
		'{OP_READ, 8'hFF, 5'd31, 7'd127, 1'b1, '{5'd0, 7'd0,  8'h00, 8'h00}},
		'{OP_READ, 8'h00, 5'd25, 7'd0,   1'b1, '{5'd0, 7'd0,  8'h00, 8'h00}},
		'{OP_READ, 8'h00, 5'd0,  7'd80,  1'b1, '{5'd0, 7'd0,  8'h00, 8'h00}},
		'{OP_PUT,  CH_BS, 5'd0,  7'd0,   1'b1, '{5'd0, 7'd0,  8'h00, 8'h00}},
		'{OP_PUT,  8'h41, 5'd31, 7'd127, 1'b1, '{5'd0, 7'd1,  8'h00, 8'h00}},
		'{OP_READ, 8'h00, 5'd0,  7'd0,   1'b1, '{5'd0, 7'd1,  8'h41, 8'h01}},
		'{OP_PUT,  8'hFF, 5'd0,  7'd0,   1'b1, '{5'd0, 7'd2,  8'h00, 8'h00}},
		'{OP_PUT,  8'h00, 5'd0,  7'd0,   1'b1, '{5'd0, 7'd3,  8'h00, 8'h00}},
		'{OP_PUT,  CH_TAB, 5'd0, 7'd0,   1'b1, '{5'd0, 7'd8,  8'h00, 8'h00}},
		'{OP_READ, 8'h00, 5'd0,  7'd5,   1'b1, '{5'd0, 7'd8,  8'h20, 8'h01}},
		'{OP_PUT,  CH_CR, 5'd0,  7'd0,   1'b1, '{5'd0, 7'd0,  8'h00, 8'h00}},
		'{OP_PUT,  CH_BS, 5'd0,  7'd0,   1'b1, '{5'd0, 7'd0,  8'h00, 8'h00}},
		'{OP_PUT,  CH_LF, 5'd0,  7'd0,   1'b1, '{5'd1, 7'd0,  8'h00, 8'h00}},
		'{OP_PUT,  CH_BS, 5'd0,  7'd0,   1'b1, '{5'd0, 7'd79, 8'h00, 8'h00}},
		'{OP_PUT,  8'h78, 5'd0,  7'd0,   1'b1, '{5'd0, 7'd80, 8'h00, 8'h00}},
		'{OP_PUT,  CH_BS, 5'd0,  7'd0,   1'b1, '{5'd0, 7'd79, 8'h00, 8'h00}},
		'{OP_PUT,  8'h79, 5'd0,  7'd0,   1'b1, '{5'd0, 7'd80, 8'h00, 8'h00}},
		'{OP_PUT,  CH_TAB, 5'd0, 7'd0,   1'b1, '{5'd1, 7'd8,  8'h00, 8'h00}},
		'{OP_READ, 8'h00, 5'd0,  7'd79,  1'b1, '{5'd1, 7'd8,  8'h79, 8'h01}},
		'{OP_PUT,  8'h7F, 5'd0,  7'd0,   1'b0, NO_VIEW},
		'{OP_READ, 8'h00, 5'd1,  7'd0,   1'b0, NO_VIEW},
		'{OP_READ, 8'h00, 5'd0,  7'd2,   1'b1, '{5'd1, 7'd9,  8'h00, 8'h01}},
		'{OP_PUT,  CH_LF, 5'd0,  7'd0,   1'b0, NO_VIEW}
	};

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		logic [7:0] phase_attr [4];
		logic       o;
		logic [7:0] ch;
		logic [4:0] rr;
		logic [6:0] rc;
		int         pick;

		foreach (screen_mirror[i])
			screen_mirror[i] = 16'h0000;
		cur_row        = 0;
		cur_col        = 0;
		attr_shadow    = ATTR_RESET;
		mismatch_count = 0;
		burst_left     = 0;
		quiet_bursts   = 1'b0;
		phase_attr     = '{8'hFF, 8'h00, 8'h00, 8'h80};
		phase_attr[2]  = $urandom_range(0, 255);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed part under the reset attribute
		foreach (directed_table[i])
			send_request(directed_table[i].op, directed_table[i].ch, directed_table[i].rr,
				directed_table[i].rc, directed_table[i].typed, directed_table[i].want);
		drain_results();

		// random phases, one attribute each
		for (int p = 0; p < 4; p++) begin
			set_attribute(phase_attr[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				o    = OP_PUT;
				ch   = 8'h00;
				rr   = 5'($urandom_range(0, 31));
				rc   = 7'($urandom_range(0, 127));
				if (pick < 25) begin
					// cell read, mostly around the cursor
					o = OP_READ;
					case ($urandom_range(0, 9))
						0: begin end
						1, 2: begin
							rr = 5'($urandom_range(0, ROWS - 1));
							rc = 7'($urandom_range(0, COLUMNS - 1));
						end
						default: begin
							rr = 5'((cur_row > 0 && $urandom_range(0, 2) == 0) ?
								cur_row - 1 : cur_row);
							rc = 7'($urandom_range(0, COLUMNS - 1));
						end
					endcase
					ch = 8'($urandom_range(0, 255));
				end else if (pick < 65) begin
					ch = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) :
						8'($urandom_range(8'h20, 8'h7E));
				end else if (pick < 73) begin
					ch = CH_TAB;
				end else if (pick < 78) begin
					ch = CH_CR;
				end else if (pick < 84) begin
					ch = CH_LF;
				end else begin
					ch = CH_BS;
				end
				send_request(o, ch, rr, rc, 1'b0, NO_VIEW);
			end
			drain_results();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && cursor_cell_q.size() == 0)
			$display("[text_console_engine] OK");
		else
			$display("[text_console_engine] ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// result side: stall pattern that changes mode from time to time
	// ------------------------------------------------------------------
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_span = 0;
	int          run_left   = 0;
	logic        run_level  = 1'b0;

	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_span = $urandom_range(32, 400);
			stall_mode = stall_mode_t'($urandom_range(0, 3));
		end
		stall_span--;
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 1) == 0);
			default: begin
				if (run_left == 0) begin
					run_left  = $urandom_range(1, 16);
					run_level = ~run_level;
				end
				run_left--;
				out_stall <= run_level;
			end
		endcase
	end

	// result check against the oldest expectation
	initial result_index = 0;

	always @(posedge clk) begin
		console_view_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (cursor_cell_q.size() == 0) begin
				report_mismatch($sformatf("result %0d with nothing expected", result_index));
			end else begin
				want = cursor_cell_q.pop_front();
				if (caret_row !== want.row)
					report_mismatch($sformatf("result %0d caret_row %0d, expected %0d",
						result_index, caret_row, want.row));
				if (caret_col !== want.col)
					report_mismatch($sformatf("result %0d caret_col %0d, expected %0d",
						result_index, caret_col, want.col));
				if (cell_char !== want.ch)
					report_mismatch($sformatf("result %0d cell_char %h, expected %h",
						result_index, cell_char, want.ch));
				if (cell_attr !== want.attr)
					report_mismatch($sformatf("result %0d cell_attr %h, expected %h",
						result_index, cell_attr, want.attr));
			end
			result_index++;
		end
	end

	// run limit
	initial cycle_count = 0;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= RUN_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				cursor_cell_q.size());
			$display("[text_console_engine] ERROR");
			$finish;
		end
	end

endmodule
